@@ rtl/core/mcsp_pkg.sv @@
// Package for the multi-channel servo pulse generator.
// Holds the request/result structs, operation codes, register indexes and reset values.
// No dependencies.
package mcsp_pkg;

  localparam int unsigned POS_W   = 8;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned BASE_W  = 16;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned CFG_W   = 16;
  // base + step * pos never needs more than this
  localparam int unsigned SUM_W   = 18;

  localparam logic [BASE_W-1:0] BASE_RESET = 16'd1125;
  localparam logic [STEP_W-1:0] STEP_RESET = 8'd25;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef enum logic {
    REG_BASE_WIDTH = 1'b0,
    REG_STEP_WIDTH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t              operation;
    logic [IDX_W-1:0] servo_index;
    logic [POS_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] servo_levels;
    logic               set_accepted;
    logic               frame_start;
  } res_t;

endpackage

@@ rtl/core/mcsp_if.sv @@
// Request and result channel interfaces for the servo pulse generator.
// Depends on mcsp_pkg.
interface mcsp_in_if
  import mcsp_pkg::*;
  ();
  logic             valid;
  logic             ready;
  op_t              operation;
  logic [IDX_W-1:0] servo_index;
  logic [POS_W-1:0] position;

  modport source (output valid, operation, servo_index, position, input ready);
  modport sink   (input valid, operation, servo_index, position, output ready);
endinterface

interface mcsp_out_if
  import mcsp_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] servo_levels;
  logic               set_accepted;
  logic               frame_start;

  modport source (output valid, servo_levels, set_accepted, frame_start, input ready);
  modport sink   (input valid, servo_levels, set_accepted, frame_start, output ready);
endinterface

@@ rtl/core/multi_channel_servo_pulse_generator_unit.sv @@
// Top level of the multi-channel servo pulse generator.
// Depends on mcsp_pkg, mcsp_if, mcsp_frame_core.
//
// Drives SERVO_COUNT servo pulses inside a repeating frame of 2^FRAME_BITS ticks.
// Each request is either a tick (advance the frame by one) or a set (store a
// pulse width for one servo). Position 0 turns a servo off; any other position p
// gives base_width + step_width * p ticks, clipped to the frame length. New widths
// are held as pending and only go live at tick 0 of the next frame. At tick 0
// every servo with a nonzero width goes high, and each goes low once its width
// has elapsed; servos with equal widths drop together. Every request gives
// exactly one result: the levels of servos 0..7 after the request, whether a set
// hit a valid servo, and whether a tick opened a frame. Throughput is one request
// per clock while the result register is not stalled; each request passes the input
// register, then the result register, with the width multiply and the parallel
// width compares between them. A stalled result register backs up into the input
// register, and in_chan.ready drops only when both are full. Config writes
// (cfg_index 0 = base_width, 1 = step_width) are meant for idle periods only.
module multi_channel_servo_pulse_generator_unit
  import mcsp_pkg::*;
#(
  parameter int unsigned SERVO_COUNT = 8,
  parameter int unsigned FRAME_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  mcsp_in_if.sink          in_chan,
  mcsp_out_if.source       out_chan,
  input  logic             cfg_we,
  input  reg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // config registers
  logic [BASE_W-1:0] base_r;
  logic [STEP_W-1:0] step_r;

  // input stage
  req_t item_r;
  logic item_vld_r;

  // result stage
  res_t out_r;
  logic out_vld_r;

  res_t res;
  logic fire;
  logic take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      step_r <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_WIDTH: base_r <= cfg_wdata;
        REG_STEP_WIDTH: step_r <= cfg_wdata[STEP_W-1:0];
        default:        ;
      endcase
    end
  end

  // fire: the held request is processed and moves into the result register
  assign fire          = item_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !item_vld_r || fire;
  assign take          = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      item_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.operation   <= in_chan.operation;
      item_r.servo_index <= in_chan.servo_index;
      item_r.position    <= in_chan.position;
    end
  end

  mcsp_frame_core #(
    .SERVO_COUNT (SERVO_COUNT),
    .FRAME_BITS  (FRAME_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .req        (item_r),
    .base_width (base_r),
    .step_width (step_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.servo_levels = out_r.servo_levels;
  assign out_chan.set_accepted = out_r.set_accepted;
  assign out_chan.frame_start  = out_r.frame_start;

  // a processed request always lands in the result register
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed request did not reach result register");

  // a result is either a set or a tick, never both flags
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_r.set_accepted && out_r.frame_start))
    else $error("set_accepted and frame_start both set");

  // backpressure only when both stages hold a request
  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (item_vld_r && out_vld_r && !out_chan.ready))
    else $error("input stalled with free room");

  // a result held under stall keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_chan.ready) |=> (out_vld_r && $stable(out_r)))
    else $error("stalled result changed");

endmodule

@@ rtl/core/mcsp_width_calc.sv @@
// Position to pulse width conversion, saturated at the frame length.
// Combinational; depends on mcsp_pkg.
module mcsp_width_calc
  import mcsp_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic [POS_W-1:0]    position,
  input  logic [BASE_W-1:0]   base_width,
  input  logic [STEP_W-1:0]   step_width,
  output logic [FRAME_BITS:0] width
);

  localparam int unsigned W     = FRAME_BITS + 1;
  localparam int unsigned CMP_W = (W > SUM_W) ? W : SUM_W;

  logic [BASE_W-1:0] prod;
  logic [CMP_W-1:0]  sum;
  logic [CMP_W-1:0]  frame_len;

  always_comb begin
    prod      = BASE_W'(step_width) * BASE_W'(position);
    sum       = CMP_W'(base_width) + CMP_W'(prod);
    frame_len = CMP_W'(1) << FRAME_BITS;
    if (position == '0) begin
      width = '0;
    end else if (sum > frame_len) begin
      width = W'(frame_len);
    end else begin
      width = W'(sum);
    end
  end

endmodule

@@ rtl/core/mcsp_frame_core.sv @@
// Width store, frame counter and per-servo level compare.
// Depends on mcsp_pkg and mcsp_width_calc.
module mcsp_frame_core
  import mcsp_pkg::*;
#(
  parameter int unsigned SERVO_COUNT = 8,
  parameter int unsigned FRAME_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  req_t              req,
  input  logic [BASE_W-1:0] base_width,
  input  logic [STEP_W-1:0] step_width,
  output res_t              res
);

  localparam int unsigned W = FRAME_BITS + 1;

  logic [W-1:0]           pending_r [SERVO_COUNT];
  logic [W-1:0]           active_r  [SERVO_COUNT];
  logic [W-1:0]           active_nxt[SERVO_COUNT];
  logic                   changed_r;
  logic [FRAME_BITS-1:0]  tick_r;
  logic [SERVO_COUNT-1:0] levels_r;
  logic [SERVO_COUNT-1:0] levels_nxt;
  logic [SERVO_COUNT-1:0] levels_cur;
  logic [W-1:0]           new_width;
  logic                   is_set;
  logic                   is_tick;
  logic                   idx_ok;
  logic                   at_start;
  logic                   reload;

  mcsp_width_calc #(.FRAME_BITS(FRAME_BITS)) u_width (
    .position   (req.position),
    .base_width (base_width),
    .step_width (step_width),
    .width      (new_width)
  );

  always_comb begin
    is_set   = (req.operation == OP_SET);
    is_tick  = (req.operation == OP_TICK);
    idx_ok   = (req.servo_index < IDX_W'(SERVO_COUNT));
    at_start = (tick_r == '0);
    reload   = at_start && changed_r;
    for (int k = 0; k < SERVO_COUNT; k++) begin
      active_nxt[k] = reload ? pending_r[k] : active_r[k];
      levels_nxt[k] = (active_nxt[k] != '0) && (W'(tick_r) < active_nxt[k]);
    end
    levels_cur = is_tick ? levels_nxt : levels_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SERVO_COUNT; k++) begin
        pending_r[k] <= '0;
        active_r[k]  <= '0;
      end
      changed_r <= 1'b1;
      tick_r    <= '0;
      levels_r  <= '0;
    end else if (fire) begin
      if (is_set) begin
        if (idx_ok) begin
          for (int k = 0; k < SERVO_COUNT; k++) begin
            if (req.servo_index == IDX_W'(k)) begin
              pending_r[k] <= new_width;
            end
          end
          changed_r <= 1'b1;
        end
      end else begin
        if (reload) begin
          for (int k = 0; k < SERVO_COUNT; k++) begin
            active_r[k] <= pending_r[k];
          end
          changed_r <= 1'b0;
        end
        levels_r <= levels_nxt;
        tick_r   <= tick_r + FRAME_BITS'(1);
      end
    end
  end

  // only the low eight servos are visible on the result
  for (genvar g = 0; g < LEVEL_W; g++) begin : g_lvl
    if (g < SERVO_COUNT) begin : g_on
      assign res.servo_levels[g] = levels_cur[g];
    end else begin : g_off
      assign res.servo_levels[g] = 1'b0;
    end
  end

  assign res.set_accepted = is_set && idx_ok;
  assign res.frame_start  = is_tick && at_start;

endmodule
